// File: rtl/spq_pkg.sv
// Package for the sorted priority queue: operation codes, the item and result
// structs and the command struct between the controller and the datapath.
// It depends on nothing else.
package spq_pkg;

    // Default number of cells in the queue.
    localparam int SPQ_DEPTH = 16;

    // Field widths.
    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int ID_W  = 8;
    localparam int OCC_W = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // One input transaction.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  requester_id;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic [ID_W-1:0]  out_id;
        logic [KEY_W-1:0] out_key;
        logic             found;
        logic             empty_error;
        logic             full_error;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } cmd_t;

endpackage

// File: rtl/spq_datapath.sv
// Datapath of the sorted priority queue: the shifting cell array, the entry
// count, the per-cell compare flags and the result register.
// Depends on spq_pkg.
module spq_datapath #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  spq_pkg::cmd_t    cmd,
    input  spq_pkg::item_t   item,
    output spq_pkg::result_t result
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // Latched transaction.
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_in_reg;
    logic [ID_W-1:0]  id_in_reg;

    // Cell array and entry count.
    logic [KEY_W-1:0] key_reg [DEPTH];
    logic [ID_W-1:0]  id_reg  [DEPTH];
    logic [KEY_W-1:0] key_next [DEPTH];
    logic [ID_W-1:0]  id_next  [DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    // Compare flags, one per cell, computed in the evaluate cycle.
    logic [DEPTH-1:0] gt_reg;
    logic [DEPTH-1:0] gt_next;
    logic [DEPTH-1:0] match_reg;
    logic [DEPTH-1:0] match_next;
    logic [DEPTH-1:0] shift_in;
    logic             full_reg;
    logic             empty_reg;

    logic             push_ok;
    logic             pop_ok;
    result_t          result_reg;
    result_t          result_next;
    logic [CW+OCC_W-1:0] occ_wide;

    // Transaction latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= item.op;
            key_in_reg <= item.key;
            id_in_reg  <= item.requester_id;
        end
    end

    // Per-cell compares against the latched key and id; only valid cells count.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt_next[i]    = (CW'(i) < count_reg) && (key_reg[i] > key_in_reg);
            match_next[i] = (CW'(i) < count_reg) && (id_reg[i] == id_in_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            gt_reg    <= gt_next;
            match_reg <= match_next;
            full_reg  <= (count_reg == CW'(DEPTH));
            empty_reg <= (count_reg == '0);
        end
    end

    assign push_ok  = (op_reg == OP_PUSH) && !full_reg;
    assign pop_ok   = (op_reg == OP_POP) && !empty_reg;
    assign shift_in = {gt_reg[DEPTH-2:0], 1'b0};

    // Next cell contents: a push shifts the larger keys one cell back and drops
    // the new entry into the gap; a pop shifts every cell one place forward.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            key_next[i] = key_reg[i];
            id_next[i]  = id_reg[i];
        end
        if (push_ok)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!shift_in[i] && (gt_reg[i] || (CW'(i) == count_reg)))
                begin
                    key_next[i] = key_in_reg;
                    id_next[i]  = id_in_reg;
                end
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (shift_in[i])
                begin
                    key_next[i] = key_reg[i-1];
                    id_next[i]  = id_reg[i-1];
                end
            end
        end
        else if (pop_ok)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                key_next[i] = key_reg[i+1];
                id_next[i]  = id_reg[i+1];
            end
        end
    end

    // Entry count after the operation.
    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Result fields; the occupancy carries the low bits of the count.
    assign occ_wide = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        result_next.out_id      = pop_ok ? id_reg[0] : '0;
        result_next.out_key     = pop_ok ? key_reg[0] : '0;
        result_next.found       = (op_reg == OP_QUERY) && (|match_reg);
        result_next.empty_error = (op_reg == OP_POP) && empty_reg;
        result_next.full_error  = (op_reg == OP_PUSH) && full_reg;
        result_next.occupancy   = occ_wide[OCC_W-1:0];
    end

    // Cell array and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                key_reg[i] <= key_next[i];
                id_reg[i]  <= id_next[i];
            end
            result_reg <= result_next;
        end
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    assign result = result_reg;

    // The count never exceeds the number of cells.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // An accepted push adds exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && push_ok) |=> (count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("push did not add one entry");

endmodule

// File: rtl/spq_ctrl.sv
// Controller of the sorted priority queue: sequences load, evaluate and
// commit, and drives busy and the result strobe.
// Depends on spq_pkg.
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output spq_pkg::cmd_t cmd
);
    import spq_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       accept;

    // A new transaction may enter while the previous one commits.
    assign busy   = (state_reg == ST_EVAL);
    assign accept = start && !busy;

    always_comb
    begin
        cmd.load   = accept;
        cmd.eval   = (state_reg == ST_EVAL);
        cmd.commit = (state_reg == ST_COMMIT);
    end

    // Next state.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_EVAL : ST_IDLE;
            ST_EVAL:   state_next = ST_COMMIT;
            ST_COMMIT: state_next = accept ? ST_EVAL : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State and strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_COMMIT);
        end
    end

    assign done = done_reg;

    // An accepted transaction always makes the block busy for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
        else $error("accepted transaction not evaluated");

    // Busy lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
        else $error("busy held more than one cycle");

    // Every evaluate cycle is followed by a result strobe, registered from the commit state.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> ##1 done)
        else $error("result strobe missing");

endmodule

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: joins the controller and the
// datapath. Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// A transaction (push, pop or query) is accepted on a clock edge with start
// high and busy low. busy is high for one cycle after each accepted
// transaction while every cell compares its key and id against the input in
// parallel; in the following cycle the cell array shifts and the result is
// registered. done is high for exactly one cycle, registered from the commit
// state, with result valid in that cycle only; the receiver cannot stall it.
// A new transaction may be accepted in the same cycle that the previous one
// commits, so back-to-back transactions pass in turn through the compare
// state and the shift state. No clearing pass is needed after reset.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  spq_pkg::item_t   item,
    output logic             done,
    output spq_pkg::result_t result
);
    import spq_pkg::*;

    cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule
